@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/itchfp_pkg.sv @@
// Shared types, constants and the message length table of the ITCH framer.
// No dependencies.
package itchfp_pkg;

    localparam int TS_W    = 48;
    localparam int DLY_W   = 30;
    localparam int INV_W   = 24;
    localparam int POS_W   = 6;
    localparam int CFG_W   = 30;

    localparam logic [POS_W-1:0] TS_FIRST = 6'd5;
    localparam logic [POS_W-1:0] TS_LAST  = 6'd10;

    localparam logic             RST_PACING = 1'b1;
    localparam logic [INV_W-1:0] RST_INV    = 24'd65536;
    localparam logic [DLY_W-1:0] RST_MAX    = 30'd1000000000;
    localparam logic [DLY_W-1:0] RST_MIN    = 30'd1000;

    typedef enum logic [1:0] {
        CFG_PACING    = 2'd0,
        CFG_INV_SPEED = 2'd1,
        CFG_MAX_DELAY = 2'd2,
        CFG_MIN_DELAY = 2'd3
    } t_cfg_idx;

    // One result item minus the delay, which follows in its own pipe.
    typedef struct packed {
        logic [7:0]       data;
        logic             status;
        logic             first;
        logic             last;
        logic [7:0]       mtype;
        logic [POS_W-1:0] mlen;
        logic [TS_W-1:0]  ts;
    } t_res;

    // Message length by type byte; 0 means unknown type.
    function automatic logic [POS_W-1:0] type_length(input logic [7:0] t);
        logic [POS_W-1:0] len;
        case (t)
            8'h53: len = 6'd12;   // S
            8'h52: len = 6'd39;   // R
            8'h48: len = 6'd25;   // H
            8'h59: len = 6'd20;   // Y
            8'h4C: len = 6'd26;   // L
            8'h56: len = 6'd35;   // V
            8'h57: len = 6'd12;   // W
            8'h4B: len = 6'd28;   // K
            8'h41: len = 6'd36;   // A
            8'h46: len = 6'd40;   // F
            8'h45: len = 6'd31;   // E
            8'h43: len = 6'd36;   // C
            8'h58: len = 6'd23;   // X
            8'h44: len = 6'd19;   // D
            8'h55: len = 6'd35;   // U
            8'h50: len = 6'd44;   // P
            8'h51: len = 6'd40;   // Q
            8'h42: len = 6'd19;   // B
            8'h49: len = 6'd50;   // I
            8'h4E: len = 6'd20;   // N
            default: len = '0;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/itchfp_framer.sv @@
// Message framing state: type lookup, byte position, timestamp collection.
// Depends on itchfp_pkg.
module itchfp_framer
    import itchfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_pacing,
    output t_res              o_res,
    output logic [TS_W-1:0]   o_delta,
    output logic              o_delay_en
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_len, n_len;
    logic [7:0]       r_type, n_type;
    logic [TS_W-1:0]  r_acc, n_acc;
    logic [TS_W-1:0]  r_prev, n_prev;
    logic [POS_W-1:0] lut_len;
    logic [POS_W-1:0] pos_inc;

    assign lut_len = type_length(i_byte);
    assign pos_inc = r_pos + 6'd1;

    always_comb begin
        n_pos  = r_pos;
        n_len  = r_len;
        n_type = r_type;
        n_acc  = r_acc;
        n_prev = r_prev;
        o_res  = '0;
        o_res.data = i_byte;
        o_delta    = '0;
        o_delay_en = 1'b0;
        if (r_pos == '0) begin
            if (lut_len == '0) begin
                // unknown type byte: dropped, hunt continues
                o_res.status = 1'b1;
                o_res.mtype  = i_byte;
            end else begin
                o_res.first = 1'b1;
                o_res.mtype = i_byte;
                o_res.mlen  = lut_len;
                n_type = i_byte;
                n_len  = lut_len;
                n_acc  = '0;
                n_pos  = 6'd1;
            end
        end else begin
            if (r_pos >= TS_FIRST && r_pos <= TS_LAST) begin
                n_acc = {r_acc[TS_W-9:0], i_byte};
            end
            n_pos = pos_inc;
            o_res.mtype = r_type;
            o_res.mlen  = r_len;
            if (pos_inc >= r_len) begin
                o_res.last = 1'b1;
                o_res.ts   = n_acc;
                o_delta    = n_acc - r_prev;
                o_delay_en = i_pacing && (r_prev != '0) && (n_acc > r_prev);
                n_prev = n_acc;
                n_pos  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_len  <= '0;
            r_type <= '0;
            r_acc  <= '0;
            r_prev <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_type <= n_type;
            r_acc  <= n_acc;
            r_prev <= n_prev;
        end
    end

endmodule

@@ rtl/itchfp_delay.sv @@
// Two-stage replay delay: split 24x24 products, then shift-add, cap, floor.
// Depends on itchfp_pkg.
module itchfp_delay
    import itchfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_adv,
    input  logic [TS_W-1:0]   i_delta,
    input  logic              i_en,
    input  logic [INV_W-1:0]  i_inv_speed,
    input  logic [DLY_W-1:0]  i_max,
    input  logic [DLY_W-1:0]  i_min,
    output logic [DLY_W-1:0]  o_delay
);

    logic [TS_W-1:0]  r_p_hi, r_p_lo;
    logic             r_en;
    logic [DLY_W-1:0] r_delay;
    logic [56:0]      raw;
    logic [DLY_W-1:0] capped;

    // floor(delta * inv / 2^16) = (hi*inv << 8) + (lo*inv >> 16)
    assign raw    = {1'b0, r_p_hi, 8'd0} + {25'd0, r_p_lo[TS_W-1:16]};
    assign capped = (raw > {27'd0, i_max}) ? i_max : raw[DLY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p_hi  <= {{INV_W{1'b0}}, i_delta[TS_W-1:INV_W]} * {{INV_W{1'b0}}, i_inv_speed};
            r_p_lo  <= {{INV_W{1'b0}}, i_delta[INV_W-1:0]} * {{INV_W{1'b0}}, i_inv_speed};
            r_en    <= i_en;
            r_delay <= (r_en && capped > i_min) ? capped : '0;
        end
    end

    assign o_delay = r_delay;

endmodule

@@ rtl/itch_message_framer_pacer.sv @@
// Top level of the ITCH 5.0 message framer with replay pacing.
// Depends on itchfp_pkg, itchfp_framer and itchfp_delay.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+--------------------------------
//  in       | in        | i_valid / o_ready   | i_stream_byte
//  out      | out       | o_valid / i_ready   | o_out_byte .. o_replay_delay_ns
//  config   | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One byte per cycle sustained while the output is not stalled; each request
// passes the framer register, product register and result register to the output.
// The depth is set by the delay path: two 24x24 multiplies, then a 57-bit
// shift-add with cap and floor compares.
// The three stages move together; the pipe advances whenever the result
// register is empty or being taken, so o_ready drops only on an output stall.
// Synchronous active-low reset clears the valid bits, the framing state and
// the configuration registers (pacing on, inverse speed 1.0, cap 1 s,
// floor 1 us).
module itch_message_framer_pacer
    import itchfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input byte stream
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_stream_byte,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // framed output
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_byte_status,
    output logic              o_first_of_message,
    output logic              o_last_of_message,
    output logic [7:0]        o_message_type,
    output logic [POS_W-1:0]  o_message_length,
    output logic [TS_W-1:0]   o_message_timestamp,
    output logic [DLY_W-1:0]  o_replay_delay_ns
);

    // configuration registers
    logic             r_pacing;
    logic [INV_W-1:0] r_inv;
    logic [DLY_W-1:0] r_max;
    logic [DLY_W-1:0] r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pacing <= RST_PACING;
            r_inv    <= RST_INV;
            r_max    <= RST_MAX;
            r_min    <= RST_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PACING:    r_pacing <= i_cfg_data[0];
                CFG_INV_SPEED: r_inv    <= i_cfg_data[INV_W-1:0];
                CFG_MAX_DELAY: r_max    <= i_cfg_data[DLY_W-1:0];
                CFG_MIN_DELAY: r_min    <= i_cfg_data[DLY_W-1:0];
            endcase
        end
    end

    // pipe control: stage a (framed), b (products), c (result)
    logic r_va, r_vb, r_vc;
    logic adv;
    logic accept;

    assign adv     = !r_vc || i_ready;
    assign o_ready = adv;
    assign accept  = i_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (adv) begin
            r_va <= accept;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // framing
    t_res            fr_res;
    logic [TS_W-1:0] fr_delta;
    logic            fr_den;

    itchfp_framer u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_stream_byte),
        .i_pacing   (r_pacing),
        .o_res      (fr_res),
        .o_delta    (fr_delta),
        .o_delay_en (fr_den)
    );

    // payload pipe; delta and delay enable ride with stage a
    t_res            r_a_res, r_b_res, r_c_res;
    logic [TS_W-1:0] r_a_delta;
    logic            r_a_den;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_res   <= fr_res;
            r_a_delta <= fr_delta;
            r_a_den   <= fr_den;
            r_b_res   <= r_a_res;
            r_c_res   <= r_b_res;
        end
    end

    // delay lands in the result register alongside stage c
    itchfp_delay u_delay (
        .i_clk       (i_clk),
        .i_adv       (adv),
        .i_delta     (r_a_delta),
        .i_en        (r_a_den),
        .i_inv_speed (r_inv),
        .i_max       (r_max),
        .i_min       (r_min),
        .o_delay     (o_replay_delay_ns)
    );

    assign o_valid             = r_vc;
    assign o_out_byte          = r_c_res.data;
    assign o_byte_status       = r_c_res.status;
    assign o_first_of_message  = r_c_res.first;
    assign o_last_of_message   = r_c_res.last;
    assign o_message_type      = r_c_res.mtype;
    assign o_message_length    = r_c_res.mlen;
    assign o_message_timestamp = r_c_res.ts;

endmodule

@@ rtl/itchfp_checker.sv @@
// Port-level checks on the framer output; bound to the top level.
// Depends on itchfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module itchfp_checker
    import itchfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_valid,
    input  logic              i_ready,
    input  logic              o_byte_status,
    input  logic              o_first_of_message,
    input  logic              o_last_of_message,
    input  logic [POS_W-1:0]  o_message_length,
    input  logic [TS_W-1:0]   o_message_timestamp,
    input  logic [DLY_W-1:0]  o_replay_delay_ns
);

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "output dropped while stalled")

    `ASSERT_IMP(a_drop_clean, i_clk, i_rst_n, o_valid && o_byte_status, (o_message_length == '0) && !o_first_of_message && !o_last_of_message, "dropped byte carries message marks")

    `ASSERT_IMP(a_first_not_last, i_clk, i_rst_n, o_valid && o_first_of_message, !o_last_of_message && !o_byte_status && (o_message_length >= 6'd12), "type byte framed wrong")

    `ASSERT_IMP(a_ts_on_last, i_clk, i_rst_n, o_valid && !o_last_of_message, (o_message_timestamp == '0) && (o_replay_delay_ns == '0), "timestamp or delay off the last byte")

endmodule

bind itch_message_framer_pacer itchfp_checker u_itchfp_checker (.*);

@@ tb/itch_frame_checker.sv @@
// Scoreboard for the ITCH framer: watches the byte, config and result channels,
// predicts each framed byte and compares results in order. Depends on itchfp_pkg.
`timescale 1ns / 100ps
module itch_frame_checker
    import itchfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [7:0]        i_stream_byte,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [7:0]        i_out_byte,
    input  logic              i_byte_status,
    input  logic              i_first,
    input  logic              i_last,
    input  logic [7:0]        i_mtype,
    input  logic [POS_W-1:0]  i_mlen,
    input  logic [TS_W-1:0]   i_ts,
    input  logic [DLY_W-1:0]  i_delay,
    output int                o_mismatches,
    output int                o_outstanding
);

    typedef struct packed {
        logic [7:0]       data_b;
        logic             dropped;
        logic             is_first;
        logic             is_last;
        logic [7:0]       mtype;
        logic [POS_W-1:0] mlen;
        logic [TS_W-1:0]  ts;
        logic [DLY_W-1:0] delay;
    } t_framed_byte;

    t_framed_byte pending_bytes[$];
    int fail_cnt = 0;

    // register copies
    logic             pace_en;
    logic [INV_W-1:0] inv_speed;
    logic [DLY_W-1:0] max_dly;
    logic [DLY_W-1:0] min_dly;

    // framing state
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] cur_len;
    logic [7:0]       cur_type;
    logic [TS_W-1:0]  ts_acc;
    logic [TS_W-1:0]  prev_ts;

    assign o_mismatches = fail_cnt;

    function automatic logic [POS_W-1:0] msg_len(input logic [7:0] t);
        case (t)
            "S", "W":      return 6'd12;
            "R":           return 6'd39;
            "H":           return 6'd25;
            "Y", "N":      return 6'd20;
            "L":           return 6'd26;
            "V", "U":      return 6'd35;
            "K":           return 6'd28;
            "A", "C":      return 6'd36;
            "F", "Q":      return 6'd40;
            "E":           return 6'd31;
            "X":           return 6'd23;
            "D", "B":      return 6'd19;
            "P":           return 6'd44;
            "I":           return 6'd50;
            default:       return '0;
        endcase
    endfunction

    // Exact floor(delta * inv / 2^16), then cap and floor threshold.
    function automatic logic [DLY_W-1:0] replay_delay(input logic [TS_W-1:0] ts);
        logic [71:0] prod;
        logic [71:0] raw;
        if (prev_ts == '0 || ts <= prev_ts || !pace_en)
            return '0;
        prod = {24'd0, ts - prev_ts} * {48'd0, inv_speed};
        raw  = prod >> 16;
        if (raw > {42'd0, max_dly})
            raw = {42'd0, max_dly};
        if (raw > {42'd0, min_dly})
            return raw[DLY_W-1:0];
        return '0;
    endfunction

    task automatic frame_byte(input logic [7:0] b);
        t_framed_byte r;
        logic [POS_W-1:0] len;
        r = '0;
        r.data_b = b;
        if (pos == '0) begin
            len = msg_len(b);
            if (len == '0) begin
                r.dropped = 1'b1;
                r.mtype   = b;
                pending_bytes.push_back(r);
                return;
            end
            r.is_first = 1'b1;
            cur_type   = b;
            cur_len    = len;
            ts_acc     = '0;
            pos        = 6'd1;
        end else begin
            if (pos >= TS_FIRST && pos <= TS_LAST)
                ts_acc = {ts_acc[TS_W-9:0], b};
            pos = pos + 6'd1;
            if (pos >= cur_len) begin
                r.is_last = 1'b1;
                r.ts      = ts_acc;
                r.delay   = replay_delay(ts_acc);
                prev_ts   = ts_acc;
                pos       = '0;
            end
        end
        r.mtype = cur_type;
        r.mlen  = cur_len;
        pending_bytes.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_framed_byte w;
        if (!i_rst_n) begin
            pace_en   = 1'b1;
            inv_speed = 24'd65536;
            max_dly   = 30'd1000000000;
            min_dly   = 30'd1000;
            pos       = '0;
            cur_len   = '0;
            cur_type  = '0;
            ts_acc    = '0;
            prev_ts   = '0;
            pending_bytes.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PACING:    pace_en   = i_cfg_data[0];
                    CFG_INV_SPEED: inv_speed = i_cfg_data[INV_W-1:0];
                    CFG_MAX_DELAY: max_dly   = i_cfg_data[DLY_W-1:0];
                    CFG_MIN_DELAY: min_dly   = i_cfg_data[DLY_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                frame_byte(i_stream_byte);
            if (i_out_valid && i_out_ready) begin
                if (pending_bytes.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result, expected none, got byte %0h",
                             $time, i_out_byte);
                end else begin
                    w = pending_bytes.pop_front();
                    check_field("out_byte", w.data_b, i_out_byte);
                    check_field("byte_status", w.dropped, i_byte_status);
                    check_field("first_of_message", w.is_first, i_first);
                    check_field("last_of_message", w.is_last, i_last);
                    check_field("message_type", w.mtype, i_mtype);
                    check_field("message_length", w.mlen, i_mlen);
                    check_field("message_timestamp", w.ts, i_ts);
                    check_field("replay_delay_ns", w.delay, i_delay);
                end
            end
            o_outstanding <= pending_bytes.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Top of the ITCH framer testbench: clock, reset, byte stream, config phases
// and output back-pressure. Depends on itchfp_pkg, itch_frame_checker and the DUT.
`timescale 1ns / 100ps
module tb
    import itchfp_pkg::*;
();

    // Watchdog limit, well above the length of the slowest legal run.
    localparam int CYCLE_LIMIT = 100000;
    // The 20 known type codes, one byte each.
    localparam logic [8*20-1:0] MSG_TYPES = "SRHYLVWKAFECXDUPQBIN";
    localparam logic [7:0] TYPE_S = "S";
    localparam logic [7:0] TYPE_W = "W";

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [7:0]        i_stream_byte;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [7:0]        o_out_byte;
    logic              o_byte_status;
    logic              o_first_of_message;
    logic              o_last_of_message;
    logic [7:0]        o_message_type;
    logic [POS_W-1:0]  o_message_length;
    logic [TS_W-1:0]   o_message_timestamp;
    logic [DLY_W-1:0]  o_replay_delay_ns;

    int                mismatches;
    int                outstanding;
    int                cycle_cnt = 0;
    int                hold_left = 0;
    int                bytes_sent = 0;
    logic              calm = 1'b0;     // no stalls or gaps in the final phase
    logic [TS_W-1:0]   stream_ts = '0;  // running timestamp of generated messages

    itch_message_framer_pacer uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_stream_byte       (i_stream_byte),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_out_byte          (o_out_byte),
        .o_byte_status       (o_byte_status),
        .o_first_of_message  (o_first_of_message),
        .o_last_of_message   (o_last_of_message),
        .o_message_type      (o_message_type),
        .o_message_length    (o_message_length),
        .o_message_timestamp (o_message_timestamp),
        .o_replay_delay_ns   (o_replay_delay_ns)
    );

    itch_frame_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_stream_byte (i_stream_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_byte    (o_out_byte),
        .i_byte_status (o_byte_status),
        .i_first       (o_first_of_message),
        .i_last        (o_last_of_message),
        .i_mtype       (o_message_type),
        .i_mlen        (o_message_length),
        .i_ts          (o_message_timestamp),
        .i_delay       (o_replay_delay_ns),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stall bursts of random length, none when calm.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold_left <= $urandom_range(0, 9);
            i_ready   <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // One byte request: raise valid, hold until taken, then maybe a gap burst.
    // If no gap, valid stays high into the next request without a low pulse.
    task automatic send_byte(input logic [7:0] b);
        i_valid       <= 1'b1;
        i_stream_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // A message of type mt with timestamp ts at offsets 5..10, big-endian.
    // Filler bytes are (random & fill_and) | fill_or; 0 < cut < length truncates it.
    task automatic send_msg(input logic [7:0] mt, input logic [TS_W-1:0] ts,
                            input int cut, input logic [7:0] fill_and,
                            input logic [7:0] fill_or);
        int len;
        logic [7:0] b;
        len = int'(type_length(mt));
        if (cut > 0 && cut < len)
            len = cut;
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                b = mt;
            else if (i >= 5 && i <= 10)
                b = ts[8*(10-i) +: 8];
            else
                b = (8'($urandom_range(0, 255)) & fill_and) | fill_or;
            send_byte(b);
        end
    endtask

    // Mostly small forward steps so the delay lands between floor and cap;
    // sometimes zero, equal/backward, big jumps or a fully random stamp.
    function automatic logic [TS_W-1:0] next_ts();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       stream_ts = '0;
            1:       stream_ts = {16'($urandom), 32'($urandom)};
            2:       stream_ts = stream_ts - TS_W'($urandom_range(0, 5000));
            3, 4:    stream_ts = stream_ts + TS_W'($urandom);
            default: stream_ts = stream_ts + TS_W'($urandom_range(0, 3000000));
        endcase
        return stream_ts;
    endfunction

    // Stop the byte stream and wait until every result has come back.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] pace, input logic [CFG_W-1:0] inv,
                               input logic [CFG_W-1:0] mx, input logic [CFG_W-1:0] mn);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PACING;
        i_cfg_data <= pace;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_INV_SPEED;
        i_cfg_data <= inv;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_DELAY;
        i_cfg_data <= mx;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MIN_DELAY;
        i_cfg_data <= mn;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random traffic: mostly whole messages (short types favored so more
    // last bytes and delays come out), plus dropped junk, stray bytes that
    // may start a bogus message, and truncated messages that break framing.
    task automatic stream_random(input int n);
        int start;
        int unsigned pick;
        logic [7:0] b;
        logic [7:0] mt;
        start = bytes_sent;
        while (bytes_sent - start < n) begin
            pick = $urandom_range(0, 19);
            if ($urandom_range(0, 1) == 0)
                mt = ($urandom_range(0, 1) == 0) ? TYPE_S : TYPE_W;
            else
                mt = MSG_TYPES[8*$urandom_range(0, 19) +: 8];
            if (pick == 0) begin
                do b = 8'($urandom_range(0, 255)); while (type_length(b) != '0);
                send_byte(b);
            end else if (pick == 1) begin
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick == 2) begin
                send_msg(mt, next_ts(), $urandom_range(1, 11), 8'hFF, 8'h00);
            end else begin
                send_msg(mt, next_ts(), 0, 8'hFF, 8'h00);
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_stream_byte <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_PACING;
        i_cfg_data    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, at reset config: dropped bytes at both byte extremes,
        // a first message with no previous stamp (no delay), then a jump to
        // the all-ones stamp that must hit the cap.
        send_byte(8'h00);
        send_msg(TYPE_S, 48'd1000, 0, 8'h00, 8'h00);
        send_byte(8'hFF);
        send_msg(TYPE_W, '1, 0, 8'h00, 8'hFF);

        for (int ph = 0; ph < 7; ph++) begin
            settle();
            case (ph)
                // pacing off; upper data bits set to check the masking
                0: load_config(30'h3FFFFFFE, 30'd65536, 30'd1000000000, 30'd1000);
                // pacing on, slowest replay, widest cap, no floor
                1: load_config(30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF, 30'd0);
                // zero inverse speed: delay always zero
                2: load_config(30'd1, 30'd0, 30'd1000000000, 30'd1000);
                // cap below the floor: delay always zero
                3: load_config(30'd1, 30'd65536, 30'd500, 30'd1000);
                4: load_config(30'd1, 30'($urandom), 30'($urandom), 30'($urandom_range(0, 100000)));
                5: load_config(30'($urandom), 30'($urandom_range(1, 24'h40000)),
                               30'($urandom_range(100000, 30'h3FFFFFFF)),
                               30'($urandom_range(0, 5000)));
                default: load_config(30'd1, 30'd32768, 30'd1000000000, 30'd1000);
            endcase
            calm <= (ph == 6);
            stream_random(45);
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ itch_message_framer_pacer.f @@
+incdir+rtl
rtl/itchfp_pkg.sv
rtl/itchfp_framer.sv
rtl/itchfp_delay.sv
rtl/itch_message_framer_pacer.sv
rtl/itchfp_checker.sv
tb/itch_frame_checker.sv
tb/tb.sv
